// File: hw/rtl/klc_pkg.sv
// ----------------------------------------------------------------------------
// klc_pkg
// Shared types, key codes and register indexes for the keypad safe-lock
// controller.
// ----------------------------------------------------------------------------
package klc_pkg;

    typedef enum logic [1:0] {
        MODE_OPEN   = 2'd0,
        MODE_CLOSED = 2'd1,
        MODE_LOCKED = 2'd2,
        MODE_MASTER = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        EV_IGNORED      = 4'd0,
        EV_STORED       = 4'd1,
        EV_ENTERED      = 4'd2,
        EV_CLOSING      = 4'd3,
        EV_OPENING      = 4'd4,
        EV_WRONG        = 4'd5,
        EV_MASTER_PROMPT = 4'd6,
        EV_MASTER_OK    = 4'd7,
        EV_MASTER_WRONG = 4'd8
    } event_t;

    typedef struct packed {
        event_t      event_res;
        logic [6:0]  echo_char;
        logic [3:0]  tries_left;
        mode_t       mode;
    } result_t;

    localparam logic [7:0] KEY_NONE = 8'hFF;
    localparam logic [7:0] KEY_STAR = 8'hE7;
    localparam logic [7:0] KEY_HASH = 8'hED;

    localparam logic [6:0] CHAR_STAR = 7'h2A;

    localparam logic CFG_MASTER_CODE  = 1'b0;
    localparam logic CFG_MAX_FAILURES = 1'b1;

    localparam logic [31:0] MASTER_CODE_RST  = 32'h777B_7DB7;
    localparam logic [3:0]  MAX_FAILURES_RST = 4'd3;
    localparam logic [3:0]  FAIL_SAT         = 4'hF;

    function automatic logic [6:0] key_ascii(input logic [7:0] k);
        logic [6:0] c;
        case (k)
            8'h77:   c = 7'h31;
            8'h7B:   c = 7'h32;
            8'h7D:   c = 7'h33;
            8'h7E:   c = 7'h41;
            8'hB7:   c = 7'h34;
            8'hBB:   c = 7'h35;
            8'hBD:   c = 7'h36;
            8'hBE:   c = 7'h42;
            8'hD7:   c = 7'h37;
            8'hDB:   c = 7'h38;
            8'hDD:   c = 7'h39;
            8'hDE:   c = 7'h43;
            8'hEB:   c = 7'h30;
            8'hEE:   c = 7'h44;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/keypad_safe_lock_controller_top.sv
// ----------------------------------------------------------------------------
// keypad_safe_lock_controller_top
// Keypad safe-lock controller: code setting, closed-mode entry, lockout and
// master-code recovery.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready): one item per key press (s_op = 0, raw
// keypad code on s_key_code) or unlock button press (s_op = 1).
// Result channel (m_valid/m_ready): exactly one result per item, in order:
// event code, echo character, tries left and the mode after the item.
// Config port: cfg_we with cfg_index 0 writes the master code, index 1 the
// failure limit (low four bits); write only while no item is in flight.
// An accepted item waits in the input register; the result register loads
// from the state update when it is empty or its result is being taken.
// Throughput: one item per cycle while m_ready stays high, set by the
// combinational state update between those two registers.
// A stalled receiver holds the result register; the input register keeps
// accepting until both are full, then s_ready drops.
// Reset (aresetn low, synchronous): open mode, code store zero, counters
// zero, master code 1-2-3-4, failure limit 3, both channels empty.
// ----------------------------------------------------------------------------
module keypad_safe_lock_controller_top import klc_pkg::*; #(
    parameter int CODE_LENGTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_key_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_event_res,
    output logic [6:0]  m_echo_char,
    output logic [3:0]  m_tries_left,
    output logic [1:0]  m_mode,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int CNT_W = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    logic                        in_vld_reg;
    logic                        in_op_reg;
    logic [7:0]                  in_key_reg;
    logic                        out_vld_reg;
    result_t                     out_res_reg;

    logic [31:0]                 master_code_reg;
    logic [3:0]                  max_fail_reg;
    mode_t                       mode_reg;
    logic [CNT_W-1:0]            count_reg;
    logic                        mism_reg;
    logic [3:0]                  fail_reg;
    logic [CODE_LENGTH-1:0][7:0] store_reg;

    mode_t                       mode_next;
    logic [CNT_W-1:0]            count_next;
    logic                        mism_next;
    logic [3:0]                  fail_next;
    logic                        store_we;
    logic                        store_clear;
    result_t                     res;
    logic                        advance;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    klc_step #(.CODE_LENGTH(CODE_LENGTH)) u_step (
        .op          (in_op_reg),
        .key         (in_key_reg),
        .mode        (mode_reg),
        .count       (count_reg),
        .mism        (mism_reg),
        .fail        (fail_reg),
        .store       (store_reg),
        .master_code (master_code_reg),
        .max_fail    (max_fail_reg),
        .mode_next   (mode_next),
        .count_next  (count_next),
        .mism_next   (mism_next),
        .fail_next   (fail_next),
        .store_we    (store_we),
        .store_clear (store_clear),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_op_reg  <= s_op;
            in_key_reg <= s_key_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_code_reg <= MASTER_CODE_RST;
            max_fail_reg    <= MAX_FAILURES_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MASTER_CODE:  master_code_reg <= cfg_wdata;
                CFG_MAX_FAILURES: max_fail_reg    <= cfg_wdata[3:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_OPEN;
            count_reg <= '0;
            mism_reg  <= 1'b0;
            fail_reg  <= 4'd0;
            store_reg <= '0;
        end else if (advance) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            mism_reg  <= mism_next;
            fail_reg  <= fail_next;
            if (store_clear) begin
                store_reg <= '0;
            end else if (store_we) begin
                store_reg[count_reg[IDX_W-1:0]] <= in_key_reg;
            end
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_event_res  = out_res_reg.event_res;
    assign m_echo_char  = out_res_reg.echo_char;
    assign m_tries_left = out_res_reg.tries_left;
    assign m_mode       = out_res_reg.mode;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CODE_LENGTH))
        else $error("entry count beyond code length");

    a_locked_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_LOCKED |-> count_reg == '0 && !mism_reg)
        else $error("entry state not cleared while locked");

    a_tries_only_wrong: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res != EV_WRONG |-> m_tries_left == 4'd0)
        else $error("tries left reported outside wrong event");

    a_echo_only_keys: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_echo_char != 7'h00 |->
            m_event_res == EV_STORED || m_event_res == EV_ENTERED)
        else $error("echo character without key event");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid && m_mode == mode_reg)
        else $error("result mode differs from state after item");

endmodule

// File: hw/rtl/klc_step.sv
// ----------------------------------------------------------------------------
// klc_step
// Next-state and result logic for one keypad or button item.
// ----------------------------------------------------------------------------
module klc_step import klc_pkg::*; #(
    parameter int CODE_LENGTH = 4,
    localparam int CNT_W = $clog2(CODE_LENGTH + 1),
    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1
) (
    input  logic                        op,
    input  logic [7:0]                  key,
    input  mode_t                       mode,
    input  logic [CNT_W-1:0]            count,
    input  logic                        mism,
    input  logic [3:0]                  fail,
    input  logic [CODE_LENGTH-1:0][7:0] store,
    input  logic [31:0]                 master_code,
    input  logic [3:0]                  max_fail,
    output mode_t                       mode_next,
    output logic [CNT_W-1:0]            count_next,
    output logic                        mism_next,
    output logic [3:0]                  fail_next,
    output logic                        store_we,
    output logic                        store_clear,
    output result_t                     res
);

    logic       valid_key;
    logic       is_hash;
    logic       room;
    logic       full;
    logic [7:0] stored_digit;
    logic [7:0] master_digit;
    logic [1:0] mdig_sel;
    logic [3:0] fail_inc;
    logic       fail_lock;

    assign valid_key    = (key != KEY_NONE) && (key != KEY_STAR) && (key != KEY_HASH);
    assign is_hash      = (key == KEY_HASH);
    assign room         = count < CNT_W'(CODE_LENGTH);
    assign full         = count == CNT_W'(CODE_LENGTH);
    assign stored_digit = store[count[IDX_W-1:0]];
    assign mdig_sel     = 2'(count);
    assign fail_inc     = (fail == FAIL_SAT) ? fail : fail + 4'd1;
    assign fail_lock    = fail_inc >= max_fail;

    // digit i sits (i mod 4) bytes down from the top
    always_comb begin
        case (mdig_sel)
            2'd0:    master_digit = master_code[31:24];
            2'd1:    master_digit = master_code[23:16];
            2'd2:    master_digit = master_code[15:8];
            default: master_digit = master_code[7:0];
        endcase
    end

    always_comb begin
        mode_next      = mode;
        count_next     = count;
        mism_next      = mism;
        fail_next      = fail;
        store_we       = 1'b0;
        store_clear    = 1'b0;
        res.event_res  = EV_IGNORED;
        res.echo_char  = 7'h00;
        res.tries_left = 4'd0;
        case (mode)
            MODE_OPEN: begin
                if (!op && valid_key && room) begin
                    store_we      = 1'b1;
                    count_next    = count + CNT_W'(1);
                    res.echo_char = key_ascii(key);
                    res.event_res = EV_STORED;
                end else if (!op && is_hash) begin
                    mode_next     = MODE_CLOSED;
                    count_next    = '0;
                    mism_next     = 1'b0;
                    res.event_res = EV_CLOSING;
                end
            end
            MODE_CLOSED: begin
                if (!op && valid_key && room) begin
                    if (stored_digit != key) begin
                        mism_next = 1'b1;
                    end
                    count_next    = count + CNT_W'(1);
                    res.echo_char = CHAR_STAR;
                    res.event_res = EV_ENTERED;
                end else if (!op && is_hash && full) begin
                    if (!mism) begin
                        fail_next     = 4'd0;
                        mode_next     = MODE_OPEN;
                        res.event_res = EV_OPENING;
                    end else begin
                        fail_next      = fail_inc;
                        res.tries_left = fail_lock ? 4'd0 : max_fail - fail_inc;
                        if (fail_lock) begin
                            mode_next = MODE_LOCKED;
                        end
                        res.event_res = EV_WRONG;
                    end
                    count_next = '0;
                    mism_next  = 1'b0;
                end
            end
            MODE_LOCKED: begin
                if (op) begin
                    mode_next     = MODE_MASTER;
                    count_next    = '0;
                    mism_next     = 1'b0;
                    res.event_res = EV_MASTER_PROMPT;
                end
            end
            default: begin
                if (!op && valid_key && room) begin
                    if (master_digit != key) begin
                        mism_next = 1'b1;
                    end
                    count_next    = count + CNT_W'(1);
                    res.echo_char = CHAR_STAR;
                    res.event_res = EV_ENTERED;
                end else if (!op && is_hash && full) begin
                    if (!mism) begin
                        fail_next     = 4'd0;
                        store_clear   = 1'b1;
                        mode_next     = MODE_OPEN;
                        res.event_res = EV_MASTER_OK;
                    end else begin
                        mode_next     = MODE_LOCKED;
                        res.event_res = EV_MASTER_WRONG;
                    end
                    count_next = '0;
                    mism_next  = 1'b0;
                end
            end
        endcase
        res.mode = mode_next;
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keypad safe-lock controller. Directed runs
// cover code setting, closed entry, lockout and master recovery. Mode-aware
// random key sequences then run over several register settings, with random
// idling on both channels and one long receiver hold-off. A built-in lock
// predictor supplies the expected result of every item, and the results are
// checked in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import klc_pkg::*;

    localparam int CODE_LEN        = 4;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int MAX_REPORTS     = 10;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [7:0]  s_key_code;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_event_res;
    logic [6:0]  m_echo_char;
    logic [3:0]  m_tries_left;
    logic [1:0]  m_mode;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    // predicted lock state
    mode_t       lock_mode_q;
    logic [7:0]  code_store_q [CODE_LEN];
    int          entry_cnt_q;
    logic        mismatch_q;
    logic [3:0]  fail_cnt_q;
    logic [31:0] master_q;
    logic [3:0]  max_fail_q;

    result_t     pending_lock_results [$];
    int          live_items;
    int          error_count;
    logic        tx_burst;
    logic        rx_burst;
    logic        hold_off_req;

    keypad_safe_lock_controller_top #(
        .CODE_LENGTH (CODE_LEN)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_key_code   (s_key_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_res  (m_event_res),
        .m_echo_char  (m_echo_char),
        .m_tries_left (m_tries_left),
        .m_mode       (m_mode),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] pad_key(input int idx);
        logic [7:0] k;
        case (idx)
            0:       k = 8'h77;
            1:       k = 8'h7B;
            2:       k = 8'h7D;
            3:       k = 8'h7E;
            4:       k = 8'hB7;
            5:       k = 8'hBB;
            6:       k = 8'hBD;
            7:       k = 8'hBE;
            8:       k = 8'hD7;
            9:       k = 8'hDB;
            10:      k = 8'hDD;
            11:      k = 8'hDE;
            12:      k = 8'hEB;
            default: k = 8'hEE;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] key_char(input logic [7:0] k);
        logic [6:0] c;
        case (k)
            8'h77:   c = 7'h31;
            8'h7B:   c = 7'h32;
            8'h7D:   c = 7'h33;
            8'h7E:   c = 7'h41;
            8'hB7:   c = 7'h34;
            8'hBB:   c = 7'h35;
            8'hBD:   c = 7'h36;
            8'hBE:   c = 7'h42;
            8'hD7:   c = 7'h37;
            8'hDB:   c = 7'h38;
            8'hDD:   c = 7'h39;
            8'hDE:   c = 7'h43;
            8'hEB:   c = 7'h30;
            8'hEE:   c = 7'h44;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] master_digit(input int idx);
        return master_q[8 * ((3 - idx) & 3) +: 8];
    endfunction

    function automatic logic [7:0] pick_key();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return pad_key($urandom_range(0, 13));
    endfunction

    function automatic void reset_lock_model();
        lock_mode_q = MODE_OPEN;
        foreach (code_store_q[i])
            code_store_q[i] = 8'h00;
        entry_cnt_q = 0;
        mismatch_q  = 1'b0;
        fail_cnt_q  = 4'd0;
        master_q    = MASTER_CODE_RST;
        max_fail_q  = MAX_FAILURES_RST;
    endfunction

    function automatic result_t predict_lock_event(input logic op, input logic [7:0] key);
        result_t r;
        logic    is_key;
        logic    is_hash;
        logic    digit_bad;
        is_key  = key != KEY_NONE && key != KEY_STAR && key != KEY_HASH;
        is_hash = key == KEY_HASH;
        r.event_res  = EV_IGNORED;
        r.echo_char  = 7'h00;
        r.tries_left = 4'd0;
        case (lock_mode_q)
            MODE_OPEN: begin
                if (!op && is_key && entry_cnt_q < CODE_LEN) begin
                    code_store_q[entry_cnt_q] = key;
                    entry_cnt_q++;
                    r.echo_char = key_char(key);
                    r.event_res = EV_STORED;
                end else if (!op && is_hash) begin
                    lock_mode_q = MODE_CLOSED;
                    entry_cnt_q = 0;
                    mismatch_q  = 1'b0;
                    r.event_res = EV_CLOSING;
                end
            end
            MODE_LOCKED: begin
                if (op) begin
                    lock_mode_q = MODE_MASTER;
                    entry_cnt_q = 0;
                    mismatch_q  = 1'b0;
                    r.event_res = EV_MASTER_PROMPT;
                end
            end
            default: begin
                if (!op && is_key && entry_cnt_q < CODE_LEN) begin
                    digit_bad = (lock_mode_q == MODE_CLOSED) ?
                                code_store_q[entry_cnt_q] != key :
                                master_digit(entry_cnt_q) != key;
                    if (digit_bad)
                        mismatch_q = 1'b1;
                    entry_cnt_q++;
                    r.echo_char = CHAR_STAR;
                    r.event_res = EV_ENTERED;
                end else if (!op && is_hash && entry_cnt_q == CODE_LEN) begin
                    if (lock_mode_q == MODE_CLOSED) begin
                        if (!mismatch_q) begin
                            fail_cnt_q  = 4'd0;
                            lock_mode_q = MODE_OPEN;
                            r.event_res = EV_OPENING;
                        end else begin
                            if (fail_cnt_q < FAIL_SAT)
                                fail_cnt_q++;
                            if (fail_cnt_q >= max_fail_q)
                                lock_mode_q = MODE_LOCKED;
                            else
                                r.tries_left = max_fail_q - fail_cnt_q;
                            r.event_res = EV_WRONG;
                        end
                    end else if (!mismatch_q) begin
                        fail_cnt_q = 4'd0;
                        foreach (code_store_q[i])
                            code_store_q[i] = 8'h00;
                        lock_mode_q = MODE_OPEN;
                        r.event_res = EV_MASTER_OK;
                    end else begin
                        lock_mode_q = MODE_LOCKED;
                        r.event_res = EV_MASTER_WRONG;
                    end
                    entry_cnt_q = 0;
                    mismatch_q  = 1'b0;
                end
            end
        endcase
        r.mode = lock_mode_q;
        return r;
    endfunction

    task automatic send_key_event(input logic op, input logic [7:0] key);
        int      gap;
        result_t r;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_key_code <= key;
        do @(posedge aclk); while (!s_ready);
        r = predict_lock_event(op, key);
        pending_lock_results.push_back(r);
        if (r.event_res != EV_IGNORED)
            live_items++;
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        s_valid <= 1'b0;
        while (pending_lock_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_MASTER_CODE)
            master_q = data;
        else
            max_fail_q = data[3:0];
    endtask

    function automatic logic [31:0] random_master();
        return {pick_key(), pick_key(), pick_key(), pick_key()};
    endfunction

    // one attempt for the current mode, at times malformed, or a stray item
    task automatic drive_sequence();
        int         n;
        int         wrong_at;
        logic       src_closed;
        logic [7:0] k;
        if ($urandom_range(0, 9) == 0) begin
            send_key_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end else begin
            case (lock_mode_q)
                MODE_OPEN: begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : CODE_LEN;
                    repeat (n) send_key_event(1'b0, pick_key());
                    send_key_event(1'b0, KEY_HASH);
                end
                MODE_LOCKED: begin
                    send_key_event(1'($urandom_range(0, 4) != 0), 8'($urandom_range(0, 255)));
                end
                default: begin
                    src_closed = lock_mode_q == MODE_CLOSED;
                    n = ($urandom_range(0, 5) == 0) ? $urandom_range(CODE_LEN - 1, CODE_LEN + 1)
                                                     : CODE_LEN;
                    wrong_at = $urandom_range(0, 1) ? n : $urandom_range(0, n - 1);
                    for (int i = 0; i < n; i++) begin
                        if (i >= CODE_LEN)
                            k = pick_key();
                        else
                            k = src_closed ? code_store_q[i] : master_digit(i);
                        if (i == wrong_at)
                            k = k ^ (8'd1 << $urandom_range(0, 7));
                        send_key_event(1'b0, k);
                    end
                    send_key_event(1'b0, KEY_HASH);
                end
            endcase
        end
    endtask

    task automatic run_random_phase(input int target);
        int start;
        start = live_items;
        while (live_items - start < target)
            drive_sequence();
    endtask

    task automatic test_code_setting();
        send_key_event(1'b0, 8'h00);
        send_key_event(1'b0, KEY_STAR);
        send_key_event(1'b1, 8'h77);
        send_key_event(1'b0, 8'h77);
        send_key_event(1'b0, KEY_NONE);
        send_key_event(1'b0, 8'hFE);
        send_key_event(1'b0, 8'h7B);
        send_key_event(1'b0, 8'hEB);
        send_key_event(1'b0, KEY_HASH);
    endtask

    task automatic test_closed_entry();
        send_key_event(1'b0, KEY_HASH);
        send_key_event(1'b0, 8'h00);
        send_key_event(1'b0, 8'h77);
        send_key_event(1'b0, 8'hFE);
        send_key_event(1'b0, 8'h7B);
        send_key_event(1'b0, KEY_HASH);
        send_key_event(1'b0, KEY_HASH);
        send_key_event(1'b1, 8'hFF);
    endtask

    task automatic test_lockout_recovery();
        write_reg(CFG_MAX_FAILURES, 32'd1);
        send_key_event(1'b0, 8'h00);
        send_key_event(1'b0, 8'h77);
        send_key_event(1'b0, 8'hFE);
        send_key_event(1'b0, 8'h01);
        send_key_event(1'b0, KEY_HASH);
        send_key_event(1'b0, 8'h77);
        send_key_event(1'b1, 8'h00);
        send_key_event(1'b0, 8'h77);
        send_key_event(1'b0, 8'h7B);
        send_key_event(1'b0, 8'h7D);
        send_key_event(1'b0, 8'hB7);
        send_key_event(1'b0, KEY_HASH);
    endtask

    task automatic test_register_sweep();
        write_reg(CFG_MAX_FAILURES, {28'($urandom), 4'd3});
        run_random_phase(150);
        write_reg(CFG_MASTER_CODE, random_master());
        write_reg(CFG_MAX_FAILURES, {28'($urandom), 4'd15});
        run_random_phase(150);
        write_reg(CFG_MASTER_CODE, 32'h0000_0000);
        write_reg(CFG_MAX_FAILURES, {28'($urandom), 4'd0});
        run_random_phase(100);
        write_reg(CFG_MASTER_CODE, random_master());
        write_reg(CFG_MAX_FAILURES, {28'($urandom), 4'd1});
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        run_random_phase(150);
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        write_reg(CFG_MASTER_CODE, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_FAILURES, 32'($urandom_range(1, 15)) | 32'hFFFF_FFF0 & $urandom);
        run_random_phase(50);
        write_reg(CFG_MASTER_CODE, $urandom);
        write_reg(CFG_MASTER_CODE, random_master());
        write_reg(CFG_MAX_FAILURES, $urandom);
        run_random_phase(150);
    endtask

    task automatic test_backpressure();
        hold_off_req = 1'b1;
        tx_burst     = 1'b1;
        repeat (12) drive_sequence();
        tx_burst     = 1'b0;
    endtask

    initial begin : result_sink
        int      stall;
        result_t want;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = rx_burst ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_lock_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: ev=%0d ch=%h tries=%0d mode=%0d",
                             m_event_res, m_echo_char, m_tries_left, m_mode);
            end else begin
                want = pending_lock_results.pop_front();
                if (m_event_res !== want.event_res || m_echo_char !== want.echo_char ||
                    m_tries_left !== want.tries_left || m_mode !== want.mode) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"mismatch: expected ev=%0d ch=%h tries=%0d mode=%0d, ",
                                  "got ev=%0d ch=%h tries=%0d mode=%0d"},
                                 want.event_res, want.echo_char, want.tries_left, want.mode,
                                 m_event_res, m_echo_char, m_tries_left, m_mode);
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        wait (aresetn === 1'b1);
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        s_valid      <= 1'b0;
        s_op         <= 1'b0;
        s_key_code   <= 8'h00;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_MASTER_CODE;
        cfg_wdata    <= 32'd0;
        aresetn      <= 1'b0;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;
        hold_off_req = 1'b0;
        live_items   = 0;
        error_count  = 0;
        reset_lock_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_code_setting();
        test_closed_entry();
        test_lockout_recovery();
        test_register_sweep();
        test_backpressure();

        s_valid <= 1'b0;
        while (pending_lock_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0 && pending_lock_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/klc_pkg.sv
hw/rtl/klc_step.sv
hw/rtl/keypad_safe_lock_controller_top.sv
tb/testbench.sv
